/* hw/rtl/bprq_pkg.sv */
// ----------------------------------------------------------------------------
// bprq_pkg
// Shared sizes, codes and controller/datapath bundles for the bitmap
// priority ready-queue scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package bprq_pkg;

    localparam int LEVELS  = 32;
    localparam int THREADS = 32;

    localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int THR_W  = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int LINK_W = $clog2(THREADS + 1);

    // link value meaning "no neighbour"
    localparam logic [LINK_W-1:0] NOLINK = LINK_W'(THREADS);

    typedef enum logic [1:0] {
        REQ_INSERT   = 2'd0,
        REQ_REMOVE   = 2'd1,
        REQ_SCHEDULE = 2'd2,
        REQ_NOP      = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NONE_READY  = 2'd1,
        ST_ALREADY_Q   = 2'd2,
        ST_NOT_QUEUED  = 2'd3
    } t_status;

    typedef struct packed {
        logic    accept;
        logic    ins_wr;
        logic    ins_link;
        logic    rem_wr;
        logic    sched_upd;
        logic    load_out;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic tid_ok;
        logic tid_queued;
        logic mask_any;
        logic ins_link;
        logic out_free;
    } t_dp_sts;

    // lowest set bit of the ready bitmap
    function automatic logic [LVL_W-1:0] find_first_set(input logic [LEVELS-1:0] m);
        logic [LVL_W-1:0] idx;
        idx = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (m[i]) idx = LVL_W'(i);
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/bprq_req_if.sv */
// ----------------------------------------------------------------------------
// bprq_req_if
// Request channel: valid/ready handshake with the request word.
// ----------------------------------------------------------------------------
`default_nettype none

interface bprq_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [4:0] thread_id;
    logic [4:0] priority_req;

    modport source (output valid, output req_type, output thread_id,
                    output priority_req, input ready);
    modport sink   (input valid, input req_type, input thread_id,
                    input priority_req, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bprq_rsp_if.sv */
// ----------------------------------------------------------------------------
// bprq_rsp_if
// Response channel: valid/ready handshake with the result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface bprq_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       switched;
    logic [4:0] next_thread;
    logic [4:0] prev_thread;
    logic       prev_valid;
    logic [4:0] run_level;
    logic       any_ready;

    modport source (output valid, output status, output switched, output next_thread,
                    output prev_thread, output prev_valid, output run_level,
                    output any_ready, input ready);
    modport sink   (input valid, input status, input switched, input next_thread,
                    input prev_thread, input prev_valid, input run_level,
                    input any_ready, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bitmap_priority_ready_queue_scheduler_core.sv */
// ----------------------------------------------------------------------------
// bitmap_priority_ready_queue_scheduler_core
// Ready-queue scheduler with one FIFO list per priority level and a ready
// bitmap searched by find-first-set.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        word
//  i_req     in   valid / ready    req_type, thread_id, priority_req
//  o_rsp     out  valid / ready    status, switched, next_thread, prev_thread,
//                                  prev_valid, run_level, any_ready
//
//  Remove, schedule and rejected requests pass S_REM_WR, S_SCHED or S_FIN; insert
//  passes S_INS_WR, then S_INS_LINK when its level already holds threads: each
//  list memory has one write port; linking the old tail is a second next-link write.
//  Reset clears the bitmap, queued flags and running thread at once; the list
//  memories need no clearing pass.
//  A result waiting on o_rsp does not block the next accept; the final cycle
//  of the following request holds until the result word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_priority_ready_queue_scheduler_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bprq_req_if.sink   i_req,
    bprq_rsp_if.source o_rsp
);
    import bprq_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;

    bprq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_req_type (i_req.req_type),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    bprq_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_thread_id    (i_req.thread_id),
        .i_priority_req (i_req.priority_req),
        .i_out_ready    (o_rsp.ready),
        .o_sts          (sts),
        .o_out_valid    (o_rsp.valid),
        .o_status       (o_rsp.status),
        .o_switched     (o_rsp.switched),
        .o_next_thread  (o_rsp.next_thread),
        .o_prev_thread  (o_rsp.prev_thread),
        .o_prev_valid   (o_rsp.prev_valid),
        .o_run_level    (o_rsp.run_level),
        .o_any_ready    (o_rsp.any_ready)
    );

    assign i_req.ready = in_ready;

endmodule

`default_nettype wire

/* hw/rtl/bprq_dp.sv */
// ----------------------------------------------------------------------------
// bprq_dp
// Datapath: ready bitmap, queued flags, per-level list memories, running
// thread state and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bprq_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire bprq_pkg::t_dp_cmd i_cmd,
    input  wire logic [4:0]        i_thread_id,
    input  wire logic [4:0]        i_priority_req,
    input  wire logic              i_out_ready,
    output bprq_pkg::t_dp_sts      o_sts,
    output logic                   o_out_valid,
    output logic [1:0]             o_status,
    output logic                   o_switched,
    output logic [4:0]             o_next_thread,
    output logic [4:0]             o_prev_thread,
    output logic                   o_prev_valid,
    output logic [4:0]             o_run_level,
    output logic                   o_any_ready
);
    import bprq_pkg::*;

    // list memories
    logic [THR_W-1:0]  r_head_mem [LEVELS];
    logic [THR_W-1:0]  r_tail_mem [LEVELS];
    logic [LINK_W-1:0] r_next_mem [THREADS];
    logic [LINK_W-1:0] r_prev_mem [THREADS];
    logic [LVL_W-1:0]  r_lvl_mem  [THREADS];

    // registered read data
    logic [THR_W-1:0]  r_head_rd;
    logic [THR_W-1:0]  r_tail_rd;
    logic [LINK_W-1:0] r_next_rd;
    logic [LINK_W-1:0] r_prev_rd;
    logic [LVL_W-1:0]  r_lvl_rd;

    // captured request
    logic [THR_W-1:0]  r_tid;
    logic [LVL_W-1:0]  r_lv;

    // control state
    logic [LEVELS-1:0]  r_mask,  n_mask;
    logic [THREADS-1:0] r_queued;
    logic [THR_W-1:0]   r_run_thr, n_run_thr;
    logic               r_run_vld, n_run_vld;
    logic [LVL_W-1:0]   r_run_lvl, n_run_lvl;

    // result register
    logic               r_out_valid;
    t_status            r_out_status;
    logic               r_out_switched;
    logic [4:0]         r_out_next;
    logic [4:0]         r_out_prev;
    logic               r_out_prev_vld;
    logic [4:0]         r_out_level;
    logic               r_out_any;

    logic [LVL_W-1:0]   lv_in;
    logic [THR_W-1:0]   tid_idx;
    logic               tid_ok;
    logic [LVL_W-1:0]   hit_lv;
    logic               pv_ok, nx_ok;
    logic [THR_W-1:0]   pv_idx, nx_idx;
    logic               sw;
    logic               out_free;

    logic               head_we, tail_we, next_we, prev_we, lvl_we;
    logic [LVL_W-1:0]   head_wa, tail_wa;
    logic [THR_W-1:0]   head_wd, tail_wd;
    logic [THR_W-1:0]   next_wa, prev_wa;
    logic [LINK_W-1:0]  next_wd, prev_wd;

    always_comb begin
        lv_in   = (int'(i_priority_req) >= LEVELS) ? LVL_W'(LEVELS - 1)
                                                   : LVL_W'(i_priority_req);
        tid_idx = THR_W'(i_thread_id);
        tid_ok  = int'(i_thread_id) < THREADS;
        hit_lv  = find_first_set(r_mask);

        pv_ok   = r_prev_rd < NOLINK;
        nx_ok   = r_next_rd < NOLINK;
        pv_idx  = THR_W'(r_prev_rd);
        nx_idx  = THR_W'(r_next_rd);

        out_free = !r_out_valid || i_out_ready;
    end

    // memory write decode
    always_comb begin
        head_we = 1'b0; head_wa = r_lv; head_wd = r_tid;
        tail_we = 1'b0; tail_wa = r_lv; tail_wd = r_tid;
        next_we = 1'b0; next_wa = r_tid; next_wd = NOLINK;
        prev_we = 1'b0; prev_wa = r_tid; prev_wd = NOLINK;
        lvl_we  = i_cmd.ins_wr;

        if (i_cmd.ins_wr) begin
            head_we = !r_mask[r_lv];
            tail_we = 1'b1;
            next_we = 1'b1;
            prev_we = 1'b1;
            prev_wd = r_mask[r_lv] ? LINK_W'(r_tail_rd) : NOLINK;
        end else if (i_cmd.ins_link) begin
            next_we = 1'b1;
            next_wa = r_tail_rd;
            next_wd = LINK_W'(r_tid);
        end else if (i_cmd.rem_wr) begin
            // unlink: bridge neighbours, or move the head/tail of the level
            head_we = !pv_ok && nx_ok;
            head_wa = r_lvl_rd;
            head_wd = nx_idx;
            tail_we = !nx_ok && pv_ok;
            tail_wa = r_lvl_rd;
            tail_wd = pv_idx;
            next_we = pv_ok;
            next_wa = pv_idx;
            next_wd = r_next_rd;
            prev_we = nx_ok;
            prev_wa = nx_idx;
            prev_wd = r_prev_rd;
        end
    end

    // next values of the bitmap and running thread
    always_comb begin
        n_mask    = r_mask;
        n_run_thr = r_run_thr;
        n_run_vld = r_run_vld;
        n_run_lvl = r_run_lvl;
        sw        = i_cmd.sched_upd && (!r_run_vld || r_head_rd != r_run_thr);

        if (i_cmd.ins_wr) begin
            n_mask[r_lv] = 1'b1;
        end
        if (i_cmd.rem_wr && !pv_ok && !nx_ok) begin
            n_mask[r_lvl_rd] = 1'b0;
        end
        // bitmap is untouched since accept, so the search still names the head's level
        if (sw) begin
            n_run_thr = r_head_rd;
            n_run_vld = 1'b1;
            n_run_lvl = hit_lv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (head_we) r_head_mem[head_wa] <= head_wd;
        if (i_cmd.accept) r_head_rd <= r_head_mem[hit_lv];
    end

    always_ff @(posedge i_clk) begin
        if (tail_we) r_tail_mem[tail_wa] <= tail_wd;
        if (i_cmd.accept) r_tail_rd <= r_tail_mem[lv_in];
    end

    always_ff @(posedge i_clk) begin
        if (next_we) r_next_mem[next_wa] <= next_wd;
        if (i_cmd.accept) r_next_rd <= r_next_mem[tid_idx];
    end

    always_ff @(posedge i_clk) begin
        if (prev_we) r_prev_mem[prev_wa] <= prev_wd;
        if (i_cmd.accept) r_prev_rd <= r_prev_mem[tid_idx];
    end

    always_ff @(posedge i_clk) begin
        if (lvl_we) r_lvl_mem[r_tid] <= r_lv;
        if (i_cmd.accept) r_lvl_rd <= r_lvl_mem[tid_idx];
    end

    // captured request and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_tid <= tid_idx;
            r_lv  <= lv_in;
        end
        if (i_cmd.load_out) begin
            r_out_status   <= i_cmd.status;
            r_out_switched <= sw;
            r_out_next     <= n_run_vld ? 5'(n_run_thr) : 5'd0;
            r_out_prev     <= (sw && r_run_vld) ? 5'(r_run_thr) : 5'd0;
            r_out_prev_vld <= sw && r_run_vld;
            r_out_level    <= 5'(n_run_lvl);
            r_out_any      <= |n_mask;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_queued    <= '0;
            r_run_thr   <= '0;
            r_run_vld   <= 1'b0;
            r_run_lvl   <= LVL_W'(LEVELS - 1);
            r_out_valid <= 1'b0;
        end else begin
            r_mask    <= n_mask;
            r_run_thr <= n_run_thr;
            r_run_vld <= n_run_vld;
            r_run_lvl <= n_run_lvl;
            if (i_cmd.ins_wr) r_queued[r_tid] <= 1'b1;
            if (i_cmd.rem_wr) r_queued[r_tid] <= 1'b0;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.tid_ok     = tid_ok;
        o_sts.tid_queued = tid_ok && r_queued[tid_idx];
        o_sts.mask_any   = |r_mask;
        o_sts.ins_link   = r_mask[r_lv];
        o_sts.out_free   = out_free;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_switched    = r_out_switched;
    assign o_next_thread = r_out_next;
    assign o_prev_thread = r_out_prev;
    assign o_prev_valid  = r_out_prev_vld;
    assign o_run_level   = r_out_level;
    assign o_any_ready   = r_out_any;

endmodule

`default_nettype wire

/* hw/rtl/bprq_ctrl.sv */
// ----------------------------------------------------------------------------
// bprq_ctrl
// Request sequencer: checks a request on accept, then steps the datapath
// through the list reads and writes and the result load.
// ----------------------------------------------------------------------------
`default_nettype none

module bprq_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [1:0]        i_req_type,
    input  wire bprq_pkg::t_dp_sts i_sts,
    output logic                   o_in_ready,
    output bprq_pkg::t_dp_cmd      o_cmd
);
    import bprq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_WR,
        S_INS_LINK,
        S_REM_WR,
        S_SCHED,
        S_FIN
    } t_state;

    t_state  r_state, n_state;
    t_status r_status, n_status;
    t_req    req;
    logic    take;

    always_comb begin
        req        = t_req'(i_req_type);
        take       = (r_state == S_IDLE) && i_in_valid;
        o_in_ready = (r_state == S_IDLE);

        n_state  = r_state;
        n_status = r_status;
        o_cmd    = '0;
        o_cmd.status = r_status;

        case (r_state)
            S_IDLE: begin
                if (take) begin
                    o_cmd.accept = 1'b1;
                    n_status     = ST_OK;
                    n_state      = S_FIN;
                    case (req)
                        REQ_INSERT: begin
                            if (!i_sts.tid_ok) begin
                                n_status = ST_NOT_QUEUED;
                            end else if (i_sts.tid_queued) begin
                                n_status = ST_ALREADY_Q;
                            end else begin
                                n_state = S_INS_WR;
                            end
                        end
                        REQ_REMOVE: begin
                            if (!i_sts.tid_queued) begin
                                n_status = ST_NOT_QUEUED;
                            end else begin
                                n_state = S_REM_WR;
                            end
                        end
                        REQ_SCHEDULE: begin
                            if (!i_sts.mask_any) begin
                                n_status = ST_NONE_READY;
                            end else begin
                                n_state = S_SCHED;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_INS_WR: begin
                // tail link of a non-empty level needs a second write, in S_INS_LINK
                if (i_sts.ins_link) begin
                    o_cmd.ins_wr = 1'b1;
                    n_state      = S_INS_LINK;
                end else if (i_sts.out_free) begin
                    o_cmd.ins_wr   = 1'b1;
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_INS_LINK: begin
                if (i_sts.out_free) begin
                    o_cmd.ins_link = 1'b1;
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_REM_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.rem_wr   = 1'b1;
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_SCHED: begin
                if (i_sts.out_free) begin
                    o_cmd.sched_upd = 1'b1;
                    o_cmd.load_out  = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

endmodule

`default_nettype wire
